[src/pstm_pkg.sv]
// ----------------------------------------------------------------------------
// Planar span texture mapper package
// Request codes, register indexes, detail codes and the store write bundle.
// ----------------------------------------------------------------------------
package pstm_pkg;

  typedef enum logic [1:0] {
    REQ_LOAD_TEXEL = 2'd0,
    REQ_LOAD_SHADE = 2'd1,
    REQ_START      = 2'd2,
    REQ_STEP       = 2'd3
  } req_t;

  localparam logic [2:0] CFG_DETAIL_MODE = 3'd0;
  localparam logic [2:0] CFG_VIEW_WIDTH  = 3'd1;
  localparam logic [2:0] CFG_VIEW_HEIGHT = 3'd2;
  localparam logic [2:0] CFG_WINDOW_LEFT = 3'd3;
  localparam logic [2:0] CFG_WINDOW_TOP  = 3'd4;

  localparam logic [1:0] DETAIL_HIGH   = 2'd0;
  localparam logic [1:0] DETAIL_MEDIUM = 2'd1;
  localparam logic [1:0] DETAIL_LOW    = 2'd2;

  // Bytes per screen row inside one plane.
  localparam int ROW_BYTES = 80;

  localparam int TEX_DEPTH  = 4096;
  localparam int TEX_ADDR_W = 12;
  localparam int ADDR_W     = 14;
  localparam int OFFSET_W   = 14;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } store_wr_t;

endpackage

[src/planar_span_texture_mapper.sv]
// ----------------------------------------------------------------------------
// Planar span texture mapper
// Draws one horizontal span of a 64x64 texture, colour mapped by light level,
// into a four-plane screen: one pixel write per step item.
// ----------------------------------------------------------------------------
// Pipeline: an accepted item passes the texture read and then the colour map read,
// each with registered data, before its result appears on the master side.
// Throughput: one item per cycle; a stalled result holds the whole two-stage
// pipeline, so the slave side is ready whenever the result slot can move.
// Reset: rst clears the span state, pipeline valids and configuration to their
// defaults; the texture and colour map stores keep whatever they held.
module planar_span_texture_mapper #(
  parameter int SHADE_MAPS = 33
) (
  input  logic         clk,
  input  logic         rst,
  // Configuration write port.
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [8:0]   cfg_data,
  // Request stream.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // load_address[13:0], load_value[21:14], span_start[30:22], span_end[39:31],
  // span_row[47:40], x_fraction[79:48], y_fraction[111:80],
  // x_increment[143:112], y_increment[175:144], light_level[181:176]
  input  logic [183:0] s_axis_tdata,
  // req_type[1:0]
  input  logic [1:0]   s_axis_tuser,
  // Pixel write stream.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // plane_offset[13:0], plane_number[15:14], pixel_value[23:16]
  output logic [23:0]  m_axis_tdata,
  // last_pixel
  output logic         m_axis_tlast,
  // span_error[0]
  output logic         m_axis_tuser
);

  localparam int SEL_W       = (SHADE_MAPS > 1) ? $clog2(SHADE_MAPS) : 1;
  localparam int SHADE_DEPTH = SHADE_MAPS * 256;
  localparam int OW          = pstm_pkg::OFFSET_W;

  // Request fields.
  pstm_pkg::req_t req_type;
  logic [13:0] load_address;
  logic [7:0]  load_value;
  logic [8:0]  span_start;
  logic [8:0]  span_end;
  logic [7:0]  span_row;
  logic [31:0] x_fraction;
  logic [31:0] y_fraction;
  logic [31:0] x_increment;
  logic [31:0] y_increment;
  logic [5:0]  light_level;

  assign req_type     = pstm_pkg::req_t'(s_axis_tuser);
  assign load_address = s_axis_tdata[13:0];
  assign load_value   = s_axis_tdata[21:14];
  assign span_start   = s_axis_tdata[30:22];
  assign span_end     = s_axis_tdata[39:31];
  assign span_row     = s_axis_tdata[47:40];
  assign x_fraction   = s_axis_tdata[79:48];
  assign y_fraction   = s_axis_tdata[111:80];
  assign x_increment  = s_axis_tdata[143:112];
  assign y_increment  = s_axis_tdata[175:144];
  assign light_level  = s_axis_tdata[181:176];

  // Configuration registers.
  logic [1:0] detail_mode;
  logic [8:0] view_width;
  logic [7:0] view_height;
  logic [8:0] window_left;
  logic [7:0] window_top;

  always_ff @(posedge clk) begin
    if (rst) begin
      detail_mode <= pstm_pkg::DETAIL_HIGH;
      view_width  <= 9'd320;
      view_height <= 8'd200;
      window_left <= 9'd0;
      window_top  <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        pstm_pkg::CFG_DETAIL_MODE: detail_mode <= cfg_data[1:0];
        pstm_pkg::CFG_VIEW_WIDTH:  view_width  <= cfg_data;
        pstm_pkg::CFG_VIEW_HEIGHT: view_height <= cfg_data[7:0];
        pstm_pkg::CFG_WINDOW_LEFT: window_left <= cfg_data;
        pstm_pkg::CFG_WINDOW_TOP:  window_top  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Span state.
  logic [31:0]      cur_x_fraction;
  logic [31:0]      cur_y_fraction;
  logic [31:0]      step_x_amount;
  logic [31:0]      step_y_amount;
  logic [8:0]       current_column;
  logic [8:0]       end_column;
  logic [OW-1:0]    write_offset;
  logic [1:0]       write_plane;
  logic [SEL_W-1:0] shade_select;
  logic             span_active;

  // Pipeline control: everything moves together when the result slot is free
  // or is being taken this cycle.
  logic adv;
  logic accept;
  logic do_start;
  logic do_step;

  // Stage one holds the write position of the pixel whose reads are under way;
  // the output stage holds the finished result.
  logic          s1_valid;
  logic [OW-1:0] s1_offset;
  logic [1:0]    s1_plane;
  logic          s1_last;
  logic          s1_err;
  logic          out_valid;
  logic [OW-1:0] out_offset;
  logic [1:0]    out_plane;
  logic          out_last;
  logic          out_err;
  logic [7:0]    lookup_pixel;

  assign adv           = !out_valid || m_axis_tready;
  assign s_axis_tready = adv;
  assign accept        = s_axis_tvalid && adv;
  assign do_start      = accept && (req_type == pstm_pkg::REQ_START);
  assign do_step       = accept && (req_type == pstm_pkg::REQ_STEP) && span_active;

  // Span setup: bounds check and first screen write position.
  logic             bad_span;
  logic [10:0]      start_col;
  logic [9:0]       start_row;
  logic [OW-1:0]    start_offset;
  logic [SEL_W-1:0] start_select;

  always_comb begin
    bad_span = ({1'b0, span_end} > ({1'b0, view_width} + 10'd1)) ||
               (span_end <= span_start) || (span_row >= view_height);
    if (detail_mode == pstm_pkg::DETAIL_HIGH) begin
      start_col = {2'b00, span_start} + {2'b00, window_left};
    end else begin
      start_col = {1'b0, span_start, 1'b0} + {2'b00, window_left};
    end
    if (detail_mode >= pstm_pkg::DETAIL_LOW) begin
      start_row = {1'b0, span_row, 1'b0} + {2'b00, window_top};
    end else begin
      start_row = {2'b00, span_row} + {2'b00, window_top};
    end
    start_offset = OW'(pstm_pkg::ROW_BYTES * int'(start_row)) + OW'(start_col[10:2]);
    // A light level beyond the last colour map uses the last one.
    if (7'(light_level) < 7'(SHADE_MAPS)) begin
      start_select = SEL_W'(light_level);
    end else begin
      start_select = SEL_W'(SHADE_MAPS - 1);
    end
  end

  // Pixel step: next column, last flag and plane advance. High detail walks
  // planes 0-1-2-3; medium and low detail write pixel pairs, so the plane
  // goes to 2 and then back to 0 on the next byte.
  logic [8:0]    column_next;
  logic          step_last;
  logic [OW-1:0] write_offset_next;
  logic [1:0]    write_plane_next;

  always_comb begin
    column_next       = current_column + 9'd1;
    step_last         = (column_next == end_column);
    write_offset_next = write_offset;
    if (detail_mode == pstm_pkg::DETAIL_HIGH) begin
      if (write_plane == 2'd3) begin
        write_offset_next = write_offset + OW'(1);
        write_plane_next  = 2'd0;
      end else begin
        write_plane_next  = write_plane + 2'd1;
      end
    end else begin
      if (write_plane == 2'd2) begin
        write_offset_next = write_offset + OW'(1);
        write_plane_next  = 2'd0;
      end else begin
        write_plane_next  = 2'd2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x_fraction <= '0;
      cur_y_fraction <= '0;
      step_x_amount  <= '0;
      step_y_amount  <= '0;
      current_column <= '0;
      end_column     <= '0;
      write_offset   <= '0;
      write_plane    <= '0;
      shade_select   <= '0;
      span_active    <= 1'b0;
    end else if (do_start) begin
      if (bad_span) begin
        // A rejected span also cancels any span that was open.
        span_active <= 1'b0;
      end else begin
        cur_x_fraction <= x_fraction;
        cur_y_fraction <= y_fraction;
        step_x_amount  <= x_increment;
        step_y_amount  <= y_increment;
        current_column <= span_start;
        end_column     <= span_end;
        write_offset   <= start_offset;
        write_plane    <= start_col[1:0];
        shade_select   <= start_select;
        span_active    <= 1'b1;
      end
    end else if (do_step) begin
      cur_x_fraction <= cur_x_fraction + step_x_amount;
      cur_y_fraction <= cur_y_fraction + step_y_amount;
      current_column <= column_next;
      write_offset   <= write_offset_next;
      write_plane    <= write_plane_next;
      if (step_last) begin
        span_active <= 1'b0;
      end
    end
  end

  // Texture and colour map stores. Loads write at the edge where they are
  // accepted, so a later step always reads the new byte, and a step already
  // in the pipeline reads its colour map before a later load lands.
  pstm_pkg::store_wr_t tex_wr;
  pstm_pkg::store_wr_t shade_wr;

  always_comb begin
    tex_wr.en     = accept && (req_type == pstm_pkg::REQ_LOAD_TEXEL) &&
                    (load_address < 14'(pstm_pkg::TEX_DEPTH));
    tex_wr.addr   = load_address;
    tex_wr.data   = load_value;
    shade_wr.en   = accept && (req_type == pstm_pkg::REQ_LOAD_SHADE) &&
                    (15'(load_address) < 15'(SHADE_DEPTH));
    shade_wr.addr = load_address;
    shade_wr.data = load_value;
  end

  pstm_texel_lookup #(
    .SHADE_MAPS (SHADE_MAPS),
    .SEL_W      (SEL_W)
  ) u_lookup (
    .clk      (clk),
    .adv      (adv),
    .tex_wr   (tex_wr),
    .shade_wr (shade_wr),
    .tex_addr ({cur_y_fraction[31:26], cur_x_fraction[31:26]}),
    .sel      (shade_select),
    .pixel    (lookup_pixel)
  );

  // Stage one and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= do_step || (do_start && bad_span);
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (do_step) begin
        s1_offset <= write_offset;
        s1_plane  <= write_plane;
        s1_last   <= step_last;
        s1_err    <= 1'b0;
      end else begin
        s1_offset <= '0;
        s1_plane  <= '0;
        s1_last   <= 1'b0;
        s1_err    <= 1'b1;
      end
      out_offset <= s1_offset;
      out_plane  <= s1_plane;
      out_last   <= s1_last;
      out_err    <= s1_err;
    end
  end

  // An error result carries zeros in every other field.
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(out_err ? 8'd0 : lookup_pixel), out_plane, out_offset};
  assign m_axis_tlast  = out_last;
  assign m_axis_tuser  = out_err;

`ifndef NO_ASSERTIONS
  // An error result never closes a drawn span.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> !m_axis_tlast && (m_axis_tdata == 24'd0))
    else $error("error result with nonzero payload or last flag");

  // Nothing is presented in the cycle after reset.
  assert property (@(posedge clk) $past(rst) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

  // A step taken with an open span reaches stage one as a valid, non-error entry.
  assert property (@(posedge clk) disable iff (rst)
    do_step |=> s1_valid && !s1_err)
    else $error("step result lost in stage one");

  // Medium and low detail only write planes from the start plane toward 2 and 0.
  assert property (@(posedge clk) disable iff (rst)
    do_step && (detail_mode != pstm_pkg::DETAIL_HIGH) |=>
      (write_plane == 2'd0) || (write_plane == 2'd2))
    else $error("bad plane advance in pair mode");
`endif

endmodule

[src/pstm_texel_lookup.sv]
// ----------------------------------------------------------------------------
// Texel lookup
// Texture store and colour map store, read one after the other over two
// pipeline steps; both reads advance only when the pipeline advances.
// ----------------------------------------------------------------------------
module pstm_texel_lookup #(
  parameter int SHADE_MAPS = 33,
  parameter int SEL_W      = 6
) (
  input  logic                               clk,
  input  logic                               adv,
  input  pstm_pkg::store_wr_t                tex_wr,
  input  pstm_pkg::store_wr_t                shade_wr,
  input  logic [pstm_pkg::TEX_ADDR_W-1:0]    tex_addr,
  input  logic [SEL_W-1:0]                   sel,
  output logic [7:0]                         pixel
);

  localparam int SHADE_DEPTH  = SHADE_MAPS * 256;
  localparam int SHADE_ADDR_W = $clog2(SHADE_DEPTH);

  logic [7:0] tex_mem   [pstm_pkg::TEX_DEPTH];
  logic [7:0] shade_mem [SHADE_DEPTH];

  logic [7:0]       tex_q;
  logic [SEL_W-1:0] sel_q;
  logic [7:0]       shade_q;

  always_ff @(posedge clk) begin
    if (tex_wr.en) begin
      tex_mem[tex_wr.addr[pstm_pkg::TEX_ADDR_W-1:0]] <= tex_wr.data;
    end
    if (adv) begin
      tex_q <= tex_mem[tex_addr];
      sel_q <= sel;
    end
  end

  // The colour map index is the map number times 256 plus the texel.
  always_ff @(posedge clk) begin
    if (shade_wr.en) begin
      shade_mem[shade_wr.addr[SHADE_ADDR_W-1:0]] <= shade_wr.data;
    end
    if (adv) begin
      shade_q <= shade_mem[SHADE_ADDR_W'({sel_q, tex_q})];
    end
  end

  assign pixel = shade_q;

endmodule

[tb/sv/tb_planar_span_texture_mapper.sv]
// ----------------------------------------------------------------------------
// Planar span texture mapper testbench
// Drives load, start and step items into the span mapper and checks every pixel
// write and span error against a cycle-free predictor of the texture walk, the
// colour map lookup and the planar write position. A short directed table
// comes first. Random spans follow under several view settings and idling
// mixes, with one long output hold-off and full drains mid-run.
// ----------------------------------------------------------------------------
module tb_planar_span_texture_mapper;
  timeunit 1ns;
  timeprecision 1ps;

  import pstm_pkg::*;

  localparam int SHADE_MAPS  = 33;
  localparam int SHADE_DEPTH = SHADE_MAPS * 256;

  // Detail code three is not named by the package; the block treats it as low.
  localparam logic [1:0] DETAIL_LOW_ALIAS = 2'd3;

  // Settling wait after the last result; it covers loads, which give no result
  // but may still be in the pipeline.
  localparam int PIPE_CYCLES = 4;
  localparam int HOLD_CYCLES = 150;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 190;

  // One request item. The field order matches the tdata packing, lowest last.
  typedef struct packed {
    req_t        kind;
    logic [5:0]  light;
    logic [31:0] step_y;
    logic [31:0] step_x;
    logic [31:0] frac_y;
    logic [31:0] frac_x;
    logic [7:0]  span_row;
    logic [8:0]  x_stop;
    logic [8:0]  x_first;
    logic [7:0]  value;
    logic [13:0] addr;
  } span_req_t;

  // One result item: a pixel write or a span error.
  typedef struct packed {
    logic [13:0] offset;
    logic [1:0]  plane;
    logic [7:0]  pixel;
    logic        last;
    logic        err;
  } pixel_wr_t;

  // How a directed row is checked: by the predictor, as giving nothing, or
  // against the result typed into the row.
  typedef enum {CHK_MODEL, CHK_NONE, CHK_TYPED} check_mode_t;

  typedef struct {
    span_req_t   item;
    check_mode_t mode;
    pixel_wr_t   want;
  } plan_row_t;

  localparam pixel_wr_t SPAN_ERROR =
    pixel_wr_t'{offset: '0, plane: '0, pixel: '0, last: 1'b0, err: 1'b1};

  // Every input of the block holds a known value from time zero.
  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_index = '0;
  logic [8:0]   cfg_data = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [183:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [23:0]  m_axis_tdata;
  logic         m_axis_tlast;
  logic         m_axis_tuser;

  planar_span_texture_mapper #(
    .SHADE_MAPS(SHADE_MAPS)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Pixel writes and span errors that the predictor has promised, oldest first.
  pixel_wr_t pending_writes[$];

  int mismatches   = 0;
  int stim_count   = 0;
  int gap_pct      = 0;
  int stall_pct    = 0;
  int hold_trigger = 0;
  int hold_seen    = 0;
  int hold_left    = 0;

  // Predictor copy of the stores. The written flags let the stimulus make sure
  // that no step ever reads an entry that was never loaded.
  logic [7:0] texels [TEX_DEPTH];
  bit         tex_set [TEX_DEPTH];
  logic [7:0] shades [SHADE_DEPTH];
  bit         shade_set [SHADE_DEPTH];

  // Predictor copy of the span walk and of the view settings.
  logic [31:0] pos_x = '0, pos_y = '0, inc_x = '0, inc_y = '0;
  logic [8:0]  col_now = '0, col_end = '0;
  logic [13:0] wr_offset = '0;
  logic [1:0]  wr_plane = '0;
  logic [5:0]  map_sel = '0;
  bit          drawing = 1'b0;

  logic [1:0]  cur_detail = DETAIL_HIGH;
  logic [8:0]  cur_width = 9'd320;
  logic [7:0]  cur_height = 8'd200;
  logic [8:0]  cur_left = '0;
  logic [7:0]  cur_top = '0;

  // Texture index of the current position: six bits of row over six of column.
  function automatic logic [11:0] texel_spot();
    return {pos_y[31:26], pos_x[31:26]};
  endfunction

  // Applies one accepted item to the predictor. took is low for items the
  // block ignores; has is high when the item gives a result.
  function automatic void predict_pixel(input span_req_t it, output bit took,
                                        output bit has, output pixel_wr_t px);
    int col, line, sidx;
    logic [11:0] spot;
    logic [8:0] nxt;
    took = 1'b1;
    has  = 1'b0;
    px   = '0;
    case (it.kind)
      REQ_LOAD_TEXEL: begin
        if (it.addr < TEX_DEPTH) begin
          texels[it.addr[11:0]]  = it.value;
          tex_set[it.addr[11:0]] = 1'b1;
        end else begin
          took = 1'b0;
        end
      end
      REQ_LOAD_SHADE: begin
        if (it.addr < SHADE_DEPTH) begin
          shades[it.addr]    = it.value;
          shade_set[it.addr] = 1'b1;
        end else begin
          took = 1'b0;
        end
      end
      REQ_START: begin
        if (it.x_stop > cur_width + 1 || it.x_stop <= it.x_first ||
            it.span_row >= cur_height) begin
          // A bad span cancels whatever span was open.
          drawing = 1'b0;
          has     = 1'b1;
          px      = SPAN_ERROR;
        end else begin
          // Medium and low detail draw double-wide, low also double-tall.
          col  = ((cur_detail == DETAIL_HIGH) ? int'(it.x_first) : 2 * int'(it.x_first))
                 + int'(cur_left);
          line = ((cur_detail >= DETAIL_LOW) ? 2 * int'(it.span_row) : int'(it.span_row))
                 + int'(cur_top);
          wr_offset = 14'(ROW_BYTES * line + col / 4);
          wr_plane  = 2'(col);
          pos_x     = it.frac_x;
          pos_y     = it.frac_y;
          inc_x     = it.step_x;
          inc_y     = it.step_y;
          col_now   = it.x_first;
          col_end   = it.x_stop;
          map_sel   = (it.light < SHADE_MAPS) ? it.light : 6'(SHADE_MAPS - 1);
          drawing   = 1'b1;
        end
      end
      default: begin
        if (!drawing) begin
          took = 1'b0;
        end else begin
          spot = texel_spot();
          sidx = int'(map_sel) * 256 + int'(texels[spot]);
          nxt  = col_now + 9'd1;
          has  = 1'b1;
          px   = pixel_wr_t'{offset: wr_offset, plane: wr_plane, pixel: shades[sidx],
                             last: (nxt == col_end), err: 1'b0};
          pos_x = pos_x + inc_x;
          pos_y = pos_y + inc_y;
          // High detail walks all four planes; the others pair planes 0 and 2.
          if (cur_detail == DETAIL_HIGH) begin
            if (wr_plane == 2'd3) begin
              wr_offset = wr_offset + 14'd1;
              wr_plane  = 2'd0;
            end else begin
              wr_plane = wr_plane + 2'd1;
            end
          end else if (wr_plane == 2'd2) begin
            wr_offset = wr_offset + 14'd1;
            wr_plane  = 2'd0;
          end else begin
            wr_plane = 2'd2;
          end
          col_now = nxt;
          if (nxt == col_end) drawing = 1'b0;
        end
      end
    endcase
  endfunction

  // An item with every field random, so fields the block must ignore toggle too.
  function automatic span_req_t noise_req();
    span_req_t it;
    it.kind     = req_t'($urandom_range(0, 3));
    it.light    = 6'($urandom);
    it.step_y   = $urandom;
    it.step_x   = $urandom;
    it.frac_y   = $urandom;
    it.frac_x   = $urandom;
    it.span_row = 8'($urandom);
    it.x_stop   = 9'($urandom);
    it.x_first  = 9'($urandom);
    it.value    = 8'($urandom);
    it.addr     = 14'($urandom);
    return it;
  endfunction

  function automatic span_req_t load_req(input req_t kind, input int addr, input int value);
    span_req_t it;
    it       = noise_req();
    it.kind  = kind;
    it.addr  = 14'(addr);
    it.value = 8'(value);
    return it;
  endfunction

  function automatic span_req_t start_req(input int x_first, input int x_stop, input int row,
                                          input logic [31:0] fx, input logic [31:0] fy,
                                          input logic [31:0] sx, input logic [31:0] sy,
                                          input int light);
    span_req_t it;
    it          = noise_req();
    it.kind     = REQ_START;
    it.x_first  = 9'(x_first);
    it.x_stop   = 9'(x_stop);
    it.span_row = 8'(row);
    it.frac_x   = fx;
    it.frac_y   = fy;
    it.step_x   = sx;
    it.step_y   = sy;
    it.light    = 6'(light);
    return it;
  endfunction

  function automatic span_req_t step_req();
    span_req_t it;
    it      = noise_req();
    it.kind = REQ_STEP;
    return it;
  endfunction

  // Mostly in-range loads of either store, now and then an address past the end.
  function automatic span_req_t random_load();
    req_t kind;
    int addr;
    kind = $urandom_range(0, 1) ? REQ_LOAD_SHADE : REQ_LOAD_TEXEL;
    if ($urandom_range(99) < 15) addr = $urandom_range(0, 16383);
    else if (kind == REQ_LOAD_TEXEL) addr = $urandom_range(0, TEX_DEPTH - 1);
    else addr = $urandom_range(0, SHADE_DEPTH - 1);
    return load_req(kind, addr, $urandom);
  endfunction

  // Texture steps: half full-range, half small enough to walk neighbouring texels.
  function automatic logic [31:0] pick_step();
    return $urandom_range(0, 1) ? $urandom : ($urandom & 32'h03FF_FFFF);
  endfunction

  function automatic void compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("pixel write field %s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Offers one item, holds it until accepted, then books what it should give.
  // The sender idles between items at the rate of the current phase.
  task automatic push_item(input span_req_t it, input check_mode_t mode,
                           input pixel_wr_t want);
    bit took, has;
    pixel_wr_t px;
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.kind;
    s_axis_tdata  <= {2'b00, it.light, it.step_y, it.step_x, it.frac_y, it.frac_x,
                      it.span_row, it.x_stop, it.x_first, it.value, it.addr};
    do @(posedge clk); while (!s_axis_tready);
    predict_pixel(it, took, has, px);
    if (took) stim_count++;
    if (mode == CHK_TYPED) pending_writes.push_back(want);
    else if (mode == CHK_MODEL && has) pending_writes.push_back(px);
  endtask

  // A step on an open span first loads the texel and the colour map byte it is
  // about to read, when those were never written.
  task automatic issue(input span_req_t it, input check_mode_t mode = CHK_MODEL,
                       input pixel_wr_t want = '0);
    logic [11:0] spot;
    int sidx;
    if (it.kind == REQ_STEP && drawing) begin
      spot = texel_spot();
      if (!tex_set[spot]) push_item(load_req(REQ_LOAD_TEXEL, spot, $urandom), CHK_MODEL, '0);
      sidx = int'(map_sel) * 256 + int'(texels[spot]);
      if (!shade_set[sidx]) push_item(load_req(REQ_LOAD_SHADE, sidx, $urandom), CHK_MODEL, '0);
    end
    push_item(it, mode, want);
  endtask

  // The sender goes quiet until every promised result has come out, then lets
  // the pipeline run empty of loads as well.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (PIPE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [8:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      CFG_DETAIL_MODE: cur_detail = value[1:0];
      CFG_VIEW_WIDTH:  cur_width  = value;
      CFG_VIEW_HEIGHT: cur_height = value[7:0];
      CFG_WINDOW_LEFT: cur_left   = value;
      default:         cur_top    = value[7:0];
    endcase
  endtask

  // View settings change only with the block empty.
  task automatic program_view(input logic [1:0] detail, input int width, input int height,
                              input int left, input int top);
    settle();
    write_reg(CFG_DETAIL_MODE, 9'(detail));
    write_reg(CFG_VIEW_WIDTH, 9'(width));
    write_reg(CFG_VIEW_HEIGHT, 9'(height));
    write_reg(CFG_WINDOW_LEFT, 9'(left));
    write_reg(CFG_WINDOW_TOP, 9'(top));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Random traffic until quota items have had an effect. Most of it is whole
  // spans with random content; some spans are cut short or overrun, and the
  // rest is loads, bad spans and fully random items.
  task automatic random_stretch(input int quota);
    int stop, pick, x1, x2, row, maxlen, len, nsteps;
    stop = stim_count + quota;
    while (stim_count < stop) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        x1     = $urandom_range(0, cur_width);
        maxlen = cur_width + 1 - x1;
        // Short spans keep the run fast; a few may run up to the whole width.
        if ($urandom_range(99) < 5) len = $urandom_range(1, maxlen);
        else len = $urandom_range(1, (maxlen < 12) ? maxlen : 12);
        issue(start_req(x1, x1 + len, $urandom_range(0, cur_height - 1), $urandom,
                        $urandom, pick_step(), pick_step(),
                        ($urandom_range(99) < 80) ? $urandom_range(0, SHADE_MAPS - 1)
                                                  : $urandom_range(SHADE_MAPS, 63)));
        pick = $urandom_range(99);
        if (pick < 10) nsteps = $urandom_range(0, len - 1);
        else if (pick < 20) nsteps = len + $urandom_range(1, 3);
        else nsteps = len;
        repeat (nsteps) begin
          if ($urandom_range(99) < 8) issue(random_load());
          issue(step_req());
        end
      end else if (pick < 80) begin
        issue(random_load());
      end else if (pick < 88) begin
        // Break a bound rule or the ordering of the ends; reversed ends may also bring a bad row.
        case ($urandom_range(0, 2))
          0: begin
            x1  = $urandom_range(0, cur_width);
            x2  = $urandom_range(cur_width + 2, 511);
            row = $urandom_range(0, cur_height - 1);
          end
          1: begin
            x1  = $urandom_range(0, 511);
            x2  = $urandom_range(0, x1);
            row = $urandom_range(0, 255);
          end
          default: begin
            x1  = $urandom_range(0, cur_width);
            x2  = $urandom_range(x1 + 1, cur_width + 1);
            row = $urandom_range(cur_height, 255);
          end
        endcase
        issue(start_req(x1, x2, row, $urandom, $urandom, $urandom, $urandom,
                        $urandom_range(0, 63)));
      end else begin
        issue(noise_req());
      end
    end
  endtask

  // Output side: ready at the phase's stall rate, except during a long
  // hold-off that the stimulus asks for by bumping hold_trigger.
  always @(posedge clk) begin
    if (hold_seen != hold_trigger) begin
      hold_seen     <= hold_trigger;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Every accepted result is matched against the oldest promised one.
  always @(posedge clk) begin
    pixel_wr_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_writes.size() == 0) begin
        $error("pixel write with nothing expected: offset %0d plane %0d value %0d",
               m_axis_tdata[13:0], m_axis_tdata[15:14], m_axis_tdata[23:16]);
        mismatches++;
      end else begin
        want = pending_writes.pop_front();
        compare_field("plane_offset", want.offset, m_axis_tdata[13:0]);
        compare_field("plane_number", want.plane, m_axis_tdata[15:14]);
        compare_field("pixel_value", want.pixel, m_axis_tdata[23:16]);
        compare_field("last_pixel", want.last, m_axis_tlast);
        compare_field("span_error", want.err, m_axis_tuser);
      end
    end
  end

  initial begin
    plan_row_t plan[$];

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Start from the reset view: high detail, full 320x200 view at the origin.
    program_view(DETAIL_HIGH, 320, 200, 0, 0);

    // Directed table. Typed rows can be read straight off the rules; the rest
    // go through the predictor.
    // A step with no open span is dropped.
    plan.push_back('{step_req(), CHK_NONE, '0});
    // Smallest span at the top-left corner: one pixel, flagged last.
    plan.push_back('{load_req(REQ_LOAD_TEXEL, 0, 8'hAB), CHK_NONE, '0});
    plan.push_back('{load_req(REQ_LOAD_SHADE, 8'hAB, 8'h5C), CHK_NONE, '0});
    plan.push_back('{start_req(0, 1, 0, 0, 0, 0, 0, 0), CHK_NONE, '0});
    plan.push_back('{step_req(), CHK_TYPED, pixel_wr_t'{offset: 14'd0, plane: 2'd0,
                     pixel: 8'h5C, last: 1'b1, err: 1'b0}});
    // The span has closed, so a further step is dropped.
    plan.push_back('{step_req(), CHK_NONE, '0});
    // Loads past the end of either store are ignored.
    plan.push_back('{load_req(REQ_LOAD_TEXEL, TEX_DEPTH, 8'h11), CHK_NONE, '0});
    plan.push_back('{load_req(REQ_LOAD_SHADE, SHADE_DEPTH, 8'h22), CHK_NONE, '0});
    plan.push_back('{load_req(REQ_LOAD_SHADE, 16383, 8'hFF), CHK_NONE, '0});
    // Last texel and last byte of the last colour map.
    plan.push_back('{load_req(REQ_LOAD_TEXEL, TEX_DEPTH - 1, 8'hFF), CHK_NONE, '0});
    plan.push_back('{load_req(REQ_LOAD_SHADE, SHADE_DEPTH - 1, 8'h81), CHK_NONE, '0});
    // Bottom-right span ending one past the view, with a light level too large
    // (it saturates to the last map) and both positions at all ones.
    plan.push_back('{start_req(319, 321, 199, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 63),
                     CHK_NONE, '0});
    plan.push_back('{step_req(), CHK_TYPED, pixel_wr_t'{offset: 14'd15999, plane: 2'd3,
                     pixel: 8'h81, last: 1'b0, err: 1'b0}});
    plan.push_back('{step_req(), CHK_TYPED, pixel_wr_t'{offset: 14'd16000, plane: 2'd0,
                     pixel: 8'h81, last: 1'b1, err: 1'b0}});
    // Bad spans: end beyond the view, empty, reversed, row below the view,
    // and every bound field at all ones.
    plan.push_back('{start_req(0, 322, 0, 0, 0, 0, 0, 0), CHK_TYPED, SPAN_ERROR});
    plan.push_back('{start_req(5, 5, 0, 0, 0, 0, 0, 0), CHK_TYPED, SPAN_ERROR});
    plan.push_back('{start_req(9, 4, 0, 0, 0, 0, 0, 0), CHK_TYPED, SPAN_ERROR});
    plan.push_back('{start_req(0, 10, 200, 0, 0, 0, 0, 0), CHK_TYPED, SPAN_ERROR});
    plan.push_back('{start_req(511, 511, 255, 0, 0, 0, 0, 63), CHK_TYPED, SPAN_ERROR});
    // A bad span cancels an open one.
    plan.push_back('{start_req(0, 10, 3, 32'h0400_0000, 32'h1000_0000, 32'h0400_0000,
                               32'hFC00_0000, 5), CHK_NONE, '0});
    plan.push_back('{step_req(), CHK_MODEL, '0});
    plan.push_back('{start_req(0, 0, 3, 0, 0, 0, 0, 0), CHK_TYPED, SPAN_ERROR});
    plan.push_back('{step_req(), CHK_NONE, '0});
    // A good span replaces an open one.
    plan.push_back('{start_req(2, 8, 10, 0, 0, 0, 0, 1), CHK_NONE, '0});
    plan.push_back('{start_req(300, 301, 0, 32'h8000_0000, 32'h8000_0000, 0, 0, 32),
                     CHK_NONE, '0});
    plan.push_back('{step_req(), CHK_MODEL, '0});
    foreach (plan[i]) issue(plan[i].item, plan[i].mode, plan[i].want);

    // Random phases, each under its own view settings and idling mix: none,
    // sender idle, receiver stalling, then both.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: program_view(DETAIL_HIGH, 320, 200, 0, 0);
        1: program_view(DETAIL_MEDIUM, 320, 200, 0, 0);
        2: program_view(DETAIL_LOW, 1, 1, 319, 199);
        // Far corner in detail three: rows run past the plane and offsets wrap.
        3: program_view(DETAIL_LOW_ALIAS, 320, 200, 319, 199);
        4: program_view(DETAIL_HIGH, 1, 200, 319, 0);
        5: program_view(DETAIL_MEDIUM, 320, 1, 0, 199);
        default: program_view(2'($urandom_range(0, 3)), $urandom_range(1, 320),
                              $urandom_range(1, 200), $urandom_range(0, 319),
                              $urandom_range(0, 199));
      endcase
      case (ph % 4)
        0: begin
          gap_pct   = 0;
          stall_pct <= 0;
        end
        1: begin
          gap_pct   = 67;
          stall_pct <= 0;
        end
        2: begin
          gap_pct   = 0;
          stall_pct <= 67;
        end
        default: begin
          gap_pct   = 23;
          stall_pct <= 23;
        end
      endcase
      if (ph == 0) begin
        // The output holds off while the sender keeps offering, so the
        // pipeline fills and the input stalls; afterwards the sender waits
        // for every result before going on.
        random_stretch(PHASE_ITEMS / 2);
        hold_trigger <= hold_trigger + 1;
        random_stretch(40);
        settle();
        random_stretch(PHASE_ITEMS / 2 - 40);
      end else begin
        random_stretch(PHASE_ITEMS);
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("planar_span_texture_mapper verification clean");
    end else begin
      $display("planar_span_texture_mapper verification failed");
    end
    $finish;
  end

  // Far beyond the slowest correct run, stalls and the long hold-off included.
  initial begin
    #5000000;
    $display("planar_span_texture_mapper verification failed");
    $finish;
  end

endmodule
